### src/longest_prefix_match_table_defines.svh
// assertion macros shared by the checker
`ifndef LONGEST_PREFIX_MATCH_TABLE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_TABLE_DEFINES_SVH

// clocked check, masked while reset is low
`define LPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define LPM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/lpm_pkg.sv
`default_nettype none
package lpm_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int IFX_W  = 16;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK           = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_ROUTE     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL         = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NONE_DELETED = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } lpm_state_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  length;
    logic [IFX_W-1:0]  ifindex;
    logic [ADDR_W-1:0] next_hop;
  } lpm_entry_t;

  typedef struct packed {
    logic free;
    logic del_hit;
    logic lpm_hit;
  } lpm_match_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len >= MAX_LEN) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} >> len);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### src/lpm_ram.sv
`default_nettype none
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### src/lpm_match.sv
`default_nettype none
module lpm_match (
  input  wire lpm_pkg::lpm_entry_t                 entry,
  input  wire logic [lpm_pkg::KIND_W-1:0]          req_kind,
  input  wire logic [lpm_pkg::ADDR_W-1:0]          req_addr,
  input  wire logic [lpm_pkg::LEN_W-1:0]           req_len,
  output lpm_pkg::lpm_match_t                      result
);

  logic [lpm_pkg::ADDR_W-1:0] mask;
  logic [lpm_pkg::ADDR_W-1:0] diff;

  // one masked compare per scanned entry
  assign mask = lpm_pkg::len_mask(entry.length);
  assign diff = (req_addr ^ entry.prefix) & mask;

  always_comb begin
    result.free    = !entry.vld;
    result.del_hit = entry.vld && (req_kind == lpm_pkg::KIND_DELETE) &&
                     (entry.prefix == req_addr) && (entry.length == req_len);
    result.lpm_hit = entry.vld && (req_kind == lpm_pkg::KIND_LOOKUP) && (diff == '0);
  end

endmodule
`default_nettype wire

### src/longest_prefix_match_table.sv
// IPv4 longest-prefix-match route table with TABLE_DEPTH slots held in one RAM.
// Items are insert, delete or lookup; each gives exactly one result beat.
// After reset the table runs a clearing pass over all slots with in_stall
// high. Every item then scans all slots through one shared masked comparator,
// one slot per cycle from the RAM read port. After an accept, in_stall stays
// high until the result has been loaded into the output register, so a new
// item is not taken before the last one's result is there. The result sits in
// the output register until taken, and a result still waiting there holds off
// the next one. Insert uses the lowest free slot, delete clears all exact
// prefix/length matches, lookup returns the longest match with the lowest slot
// winning ties. A prefix length above 32 is saturated to 32. Kind 3 changes
// nothing and answers no route.
`default_nettype none
module longest_prefix_match_table #(
  parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lpm_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [lpm_pkg::ADDR_W-1:0]   in_addr,
  input  wire logic [lpm_pkg::LEN_W-1:0]    in_prefix_len,
  input  wire logic [lpm_pkg::IFX_W-1:0]    in_ifindex,
  input  wire logic [lpm_pkg::ADDR_W-1:0]   in_next_hop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [lpm_pkg::STAT_W-1:0]   out_status,
  output logic      [lpm_pkg::ADDR_W-1:0]   out_next_hop,
  output logic      [lpm_pkg::IFX_W-1:0]    out_ifindex,
  output logic      [lpm_pkg::LEN_W-1:0]    out_matched_len
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(lpm_pkg::lpm_entry_t);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_DEPTH - 1);

  lpm_pkg::lpm_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          s1_vld_r;
  logic [AW-1:0] s1_idx_r;

  logic [lpm_pkg::KIND_W-1:0] req_kind_r;
  logic [lpm_pkg::ADDR_W-1:0] req_addr_r;
  logic [lpm_pkg::LEN_W-1:0]  req_len_r;
  logic [lpm_pkg::IFX_W-1:0]  req_ifx_r;
  logic [lpm_pkg::ADDR_W-1:0] req_nh_r;

  logic                       best_found_r;
  logic [lpm_pkg::LEN_W-1:0]  best_len_r;
  logic [lpm_pkg::ADDR_W-1:0] best_nh_r;
  logic [lpm_pkg::IFX_W-1:0]  best_if_r;
  logic                       ins_done_r;
  logic                       del_any_r;

  logic                       out_valid_r;
  logic [lpm_pkg::STAT_W-1:0] out_status_r;
  logic [lpm_pkg::ADDR_W-1:0] out_nh_r;
  logic [lpm_pkg::IFX_W-1:0]  out_if_r;
  logic [lpm_pkg::LEN_W-1:0]  out_len_r;

  logic                accept;
  logic                issue;
  logic                load_out;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  lpm_pkg::lpm_entry_t wr_entry;
  lpm_pkg::lpm_entry_t rd_entry;
  logic [EW-1:0]       rd_word;
  lpm_pkg::lpm_match_t hit;
  logic                ins_now;
  logic                better;
  logic [lpm_pkg::STAT_W-1:0] fin_status;
  logic [lpm_pkg::LEN_W-1:0]  in_len_sat;

  lpm_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_word)
  );

  assign rd_entry = lpm_pkg::lpm_entry_t'(rd_word);

  lpm_match u_match (
    .entry    (rd_entry),
    .req_kind (req_kind_r),
    .req_addr (req_addr_r),
    .req_len  (req_len_r),
    .result   (hit)
  );

  assign in_len_sat = (in_prefix_len > lpm_pkg::MAX_LEN) ? lpm_pkg::MAX_LEN : in_prefix_len;
  assign ins_now    = s1_vld_r && hit.free && !ins_done_r &&
                      (req_kind_r == lpm_pkg::KIND_INSERT);
  assign better     = s1_vld_r && hit.lpm_hit &&
                      (!best_found_r || (rd_entry.length > best_len_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      lpm_pkg::S_CLEAR: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = lpm_pkg::S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      lpm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = lpm_pkg::S_SCAN;
          cnt_nxt   = '0;
        end
      end
      lpm_pkg::S_SCAN: begin
        if (cnt_r != CNT_END) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!s1_vld_r) begin
          state_nxt = lpm_pkg::S_DONE;
        end
      end
      lpm_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = lpm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lpm_pkg::S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = s1_idx_r;
    wr_entry = '0;
    case (state_r)
      lpm_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
      end
      lpm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      lpm_pkg::S_SCAN: begin
        issue = (cnt_r != CNT_END);
        if (s1_vld_r && hit.del_hit) begin
          wr_en = 1'b1;
        end else if (ins_now) begin
          wr_en    = 1'b1;
          wr_entry = '{vld: 1'b1, prefix: req_addr_r, length: req_len_r,
                       ifindex: req_ifx_r, next_hop: req_nh_r};
        end
      end
      lpm_pkg::S_DONE: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (req_kind_r)
      lpm_pkg::KIND_INSERT: fin_status = ins_done_r ? lpm_pkg::STAT_OK : lpm_pkg::STAT_FULL;
      lpm_pkg::KIND_DELETE: fin_status = del_any_r ? lpm_pkg::STAT_OK
                                                   : lpm_pkg::STAT_NONE_DELETED;
      lpm_pkg::KIND_LOOKUP: fin_status = best_found_r ? lpm_pkg::STAT_OK
                                                      : lpm_pkg::STAT_NO_ROUTE;
      default:              fin_status = lpm_pkg::STAT_NO_ROUTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpm_pkg::S_CLEAR;
      cnt_r       <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      s1_vld_r <= issue;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= cnt_r[AW-1:0];
    if (accept) begin
      req_kind_r   <= in_kind;
      req_addr_r   <= in_addr;
      req_len_r    <= in_len_sat;
      req_ifx_r    <= in_ifindex;
      req_nh_r     <= in_next_hop;
      best_found_r <= 1'b0;
      best_len_r   <= '0;
      best_nh_r    <= '0;
      best_if_r    <= '0;
      ins_done_r   <= 1'b0;
      del_any_r    <= 1'b0;
    end else begin
      if (better) begin
        best_found_r <= 1'b1;
        best_len_r   <= rd_entry.length;
        best_nh_r    <= rd_entry.next_hop;
        best_if_r    <= rd_entry.ifindex;
      end
      if (ins_now) begin
        ins_done_r <= 1'b1;
      end
      if (s1_vld_r && hit.del_hit) begin
        del_any_r <= 1'b1;
      end
    end
    if (load_out) begin
      out_status_r <= fin_status;
      out_nh_r     <= best_nh_r;
      out_if_r     <= best_if_r;
      out_len_r    <= best_len_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_next_hop    = out_nh_r;
  assign out_ifindex     = out_if_r;
  assign out_matched_len = out_len_r;

endmodule
`default_nettype wire

### src/lpm_checker.sv
`default_nettype none
`include "longest_prefix_match_table_defines.svh"
module lpm_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [lpm_pkg::STAT_W-1:0] out_status,
  input wire logic [lpm_pkg::ADDR_W-1:0] out_next_hop,
  input wire logic [lpm_pkg::IFX_W-1:0]  out_ifindex,
  input wire logic [lpm_pkg::LEN_W-1:0]  out_matched_len
);

  logic [lpm_pkg::STAT_W + lpm_pkg::ADDR_W + lpm_pkg::IFX_W + lpm_pkg::LEN_W - 1:0] out_beat;
  logic out_fail;
  logic route_zero;

  assign out_beat   = {out_status, out_next_hop, out_ifindex, out_matched_len};
  assign out_fail   = (out_status != lpm_pkg::STAT_OK);
  assign route_zero = (out_next_hop == '0) && (out_ifindex == '0) && (out_matched_len == '0);

  `LPM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")
  `LPM_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_beat), "stalled result changed")
  `LPM_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "beat taken while busy")
  `LPM_ASSERT(a_zero_on_fail, out_valid && out_fail |-> route_zero, "failed result has route data")
  `LPM_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result beat shown out of reset")

endmodule

bind longest_prefix_match_table lpm_checker u_lpm_checker (.*);
`default_nettype wire

### tb/route_table_checker.sv
`timescale 1ns / 100ps
module route_table_checker
  import lpm_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [ADDR_W-1:0] in_addr,
  input  wire logic [LEN_W-1:0]  in_prefix_len,
  input  wire logic [IFX_W-1:0]  in_ifindex,
  input  wire logic [ADDR_W-1:0] in_next_hop,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [STAT_W-1:0] out_status,
  input  wire logic [ADDR_W-1:0] out_next_hop,
  input  wire logic [IFX_W-1:0]  out_ifindex,
  input  wire logic [LEN_W-1:0]  out_matched_len,
  output int unsigned            fail_count,
  output int unsigned            pending_count
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] next_hop;
    logic [IFX_W-1:0]  ifindex;
    logic [LEN_W-1:0]  matched_len;
  } route_reply_t;

  bit                route_used   [DEPTH];
  logic [ADDR_W-1:0] route_prefix [DEPTH];
  logic [LEN_W-1:0]  route_len    [DEPTH];
  logic [IFX_W-1:0]  route_ifindex[DEPTH];
  logic [ADDR_W-1:0] route_hop    [DEPTH];

  route_reply_t expected_replies[$];
  int unsigned  mismatches = 0;

  function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
    return 32'hFFFF_FFFF << (32 - int'(len));
  endfunction

  // updates the table copy and returns the reply of one request beat
  function automatic route_reply_t route_table_apply(
    input logic [KIND_W-1:0] kind,
    input logic [ADDR_W-1:0] addr,
    input logic [LEN_W-1:0]  plen,
    input logic [IFX_W-1:0]  ifx,
    input logic [ADDR_W-1:0] hop
  );
    route_reply_t r;
    logic [LEN_W-1:0] len;
    bit found;
    r = '0;
    r.status = STAT_NO_ROUTE;
    len = (plen > MAX_LEN) ? MAX_LEN : plen;
    found = 1'b0;
    case (kind)
      KIND_INSERT: begin
        r.status = STAT_FULL;
        for (int i = 0; i < DEPTH; i++) begin
          if (!route_used[i]) begin
            route_used[i]    = 1'b1;
            route_prefix[i]  = addr;
            route_len[i]     = len;
            route_ifindex[i] = ifx;
            route_hop[i]     = hop;
            r.status = STAT_OK;
            break;
          end
        end
      end
      KIND_DELETE: begin
        r.status = STAT_NONE_DELETED;
        for (int i = 0; i < DEPTH; i++) begin
          if (route_used[i] && route_prefix[i] == addr && route_len[i] == len) begin
            route_used[i] = 1'b0;
            r.status = STAT_OK;
          end
        end
      end
      KIND_LOOKUP: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (route_used[i] && ((addr ^ route_prefix[i]) & net_mask(route_len[i])) == '0 &&
              (!found || route_len[i] > r.matched_len)) begin
            found = 1'b1;
            r.matched_len = route_len[i];
            r.next_hop    = route_hop[i];
            r.ifindex     = route_ifindex[i];
          end
        end
        if (found) begin
          r.status = STAT_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    route_reply_t want;
    route_reply_t got;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        route_used[i] = 1'b0;
      end
      expected_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_next_hop, out_ifindex, out_matched_len};
        if (expected_replies.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result beat status %0d hop %h if %h len %0d",
                     $time, got.status, got.next_hop, got.ifindex, got.matched_len);
          end
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (want != got) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch expected status %0d hop %h if %h len %0d",
                       $time, want.status, want.next_hop, want.ifindex, want.matched_len);
              $display("%0t:          actual   status %0d hop %h if %h len %0d",
                       $time, got.status, got.next_hop, got.ifindex, got.matched_len);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_replies.push_back(route_table_apply(in_kind, in_addr, in_prefix_len,
                                                     in_ifindex, in_next_hop));
      end
    end
    pending_count <= expected_replies.size();
    fail_count    <= mismatches;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import lpm_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int RANDOM_BEATS = 400;
  localparam int POOL_SIZE = 16;
  localparam int HOLD_CYCLES = 400;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [KIND_W-1:0] in_kind = '0;
  logic [ADDR_W-1:0] in_addr = '0;
  logic [LEN_W-1:0]  in_prefix_len = '0;
  logic [IFX_W-1:0]  in_ifindex = '0;
  logic [ADDR_W-1:0] in_next_hop = '0;
  logic              out_stall = 1'b0;

  wire logic              in_stall;
  wire logic              out_valid;
  wire logic [STAT_W-1:0] out_status;
  wire logic [ADDR_W-1:0] out_next_hop;
  wire logic [IFX_W-1:0]  out_ifindex;
  wire logic [LEN_W-1:0]  out_matched_len;

  int unsigned fail_count;
  int unsigned pending_count;

  int unsigned send_idle_pct = 35;
  int unsigned recv_stall_pct = 53;
  bit          long_hold_phase = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  logic [ADDR_W-1:0] pool_addr[POOL_SIZE];
  logic [LEN_W-1:0]  pool_len [POOL_SIZE];
  logic [ADDR_W-1:0] roots[3];

  always #5 clk = ~clk;

  longest_prefix_match_table #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_addr        (in_addr),
    .in_prefix_len  (in_prefix_len),
    .in_ifindex     (in_ifindex),
    .in_next_hop    (in_next_hop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_next_hop   (out_next_hop),
    .out_ifindex    (out_ifindex),
    .out_matched_len(out_matched_len)
  );

  route_table_checker #(
    .DEPTH(DEPTH)
  ) i_route_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_addr        (in_addr),
    .in_prefix_len  (in_prefix_len),
    .in_ifindex     (in_ifindex),
    .in_next_hop    (in_next_hop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_next_hop   (out_next_hop),
    .out_ifindex    (out_ifindex),
    .out_matched_len(out_matched_len),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  function automatic logic [ADDR_W-1:0] keep_mask(input logic [LEN_W-1:0] len);
    if (len > MAX_LEN) begin
      len = MAX_LEN;
    end
    return 32'hFFFF_FFFF << (32 - int'(len));
  endfunction

  task automatic push_beat(
    input logic [KIND_W-1:0] kind,
    input logic [ADDR_W-1:0] addr,
    input logic [LEN_W-1:0]  plen,
    input logic [IFX_W-1:0]  ifx,
    input logic [ADDR_W-1:0] hop
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_addr       <= addr;
    in_prefix_len <= plen;
    in_ifindex    <= ifx;
    in_next_hop   <= hop;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // receiver: random stalls, plus one long hold-off so the table backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_phase && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int k;
    int sel;
    int roll;
    bit fill;
    logic [ADDR_W-1:0] m;
    logic [LEN_W-1:0]  ln;

    for (k = 0; k < 3; k++) begin
      roots[k] = $urandom;
    end
    // route pool: default route, a host route, an over-long length, nested prefixes
    for (k = 0; k < POOL_SIZE; k++) begin
      if (k == 0) begin
        pool_len[k] = '0;
      end else if (k == 1) begin
        pool_len[k] = MAX_LEN;
      end else if (k == 2) begin
        pool_len[k] = LEN_W'($urandom_range(33, 63));
      end else begin
        pool_len[k] = LEN_W'($urandom_range(1, 32));
      end
      m = keep_mask(pool_len[k]);
      pool_addr[k] = (roots[k % 3] & m) | ((k % 2 == 1) ? ($urandom & ~m) : '0);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats
    push_beat(KIND_LOOKUP, 32'hC0A8_0101, '0, '0, '0);
    push_beat(KIND_DELETE, 32'h0A00_0000, 6'd8, '0, '0);
    push_beat(KIND_UNUSED, '1, '1, '1, '1);
    push_beat(KIND_INSERT, 32'hDEAD_BEEF, 6'd0, 16'hFFFF, 32'hFFFF_FFFF);
    push_beat(KIND_INSERT, 32'h0A00_0000, 6'd8, 16'h0001, 32'h0A00_0001);
    push_beat(KIND_INSERT, 32'h0A01_0203, 6'd16, 16'h0002, 32'h0A01_0001);
    push_beat(KIND_INSERT, 32'hC0A8_0101, 6'd40, 16'h0003, 32'hC0A8_0001);
    push_beat(KIND_INSERT, 32'hFFFF_FFFF, 6'd63, 16'h0000, 32'h0000_0000);
    push_beat(KIND_INSERT, 32'h0A00_0000, 6'd8, 16'h0005, 32'h0A00_0005);
    push_beat(KIND_LOOKUP, 32'h0A01_FFFF, '0, '0, '0);
    push_beat(KIND_LOOKUP, 32'h0AC8_0000, '0, '0, '0);
    push_beat(KIND_LOOKUP, 32'hC0A8_0101, '0, '0, '0);
    push_beat(KIND_LOOKUP, 32'hC0A8_0102, '0, '0, '0);
    push_beat(KIND_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
    push_beat(KIND_LOOKUP, 32'h0000_0000, '0, '0, '0);
    push_beat(KIND_DELETE, 32'h0A01_0000, 6'd16, '0, '0);
    push_beat(KIND_DELETE, 32'h0A01_0203, 6'd16, '0, '0);
    push_beat(KIND_DELETE, 32'hC0A8_0101, 6'd33, '0, '0);
    push_beat(KIND_DELETE, 32'h0A00_0000, 6'd8, '0, '0);
    push_beat(KIND_LOOKUP, 32'h0A01_0203, '0, '0, '0);
    push_beat(KIND_DELETE, 32'hDEAD_BEEF, 6'd0, '0, '0);
    push_beat(KIND_LOOKUP, 32'h0A01_0203, '0, '0, '0);
    push_beat(KIND_INSERT, 32'h0000_0000, 6'd0, 16'h0000, 32'h0000_0000);
    push_beat(KIND_LOOKUP, 32'h1234_5678, '0, '0, '0);

    // random beats: fill stretches run the table full, drain stretches empty it
    for (k = 0; k < RANDOM_BEATS; k++) begin
      if (k == RANDOM_BEATS / 3) begin
        send_idle_pct = 53;
        recv_stall_pct = 35;
      end
      if (k == 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold_phase = 1'b1;
      end
      fill = (k % 200) < 130;
      sel = $urandom_range(POOL_SIZE - 1);
      ln = pool_len[sel];
      m = keep_mask(ln);
      roll = $urandom_range(99);
      if (roll < 8) begin
        push_beat(KIND_W'($urandom_range(3)), $urandom, LEN_W'($urandom),
                  IFX_W'($urandom), $urandom);
      end else if (roll < (fill ? 70 : 23)) begin
        push_beat(KIND_INSERT, pool_addr[sel], ln, IFX_W'($urandom), $urandom);
      end else if (roll < (fill ? 72 : 63)) begin
        push_beat(KIND_DELETE, pool_addr[sel], ln, IFX_W'($urandom), $urandom);
      end else begin
        push_beat(KIND_LOOKUP, (pool_addr[sel] & m) | ($urandom & ~m), LEN_W'($urandom),
                  IFX_W'($urandom), $urandom);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
